// ===== src/tsrr_pkg.sv =====
package tsrr_pkg;

    localparam int DEFAULT_NUM_SLOTS = 8;

    // Widths of the transaction fields.
    localparam int CMD_W   = 2;
    localparam int ID_W    = 3;
    localparam int CODE_W  = 5;
    localparam int CLK_W   = 3;
    localparam int TURNS_W = 4;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_SCHED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXC   = 2'd2;

    // A slot clock at this code belongs to a dead task.
    localparam logic [CLK_W-1:0] CLK_DEAD = 3'd7;
    localparam logic [TURNS_W-1:0] TURNS_RESET = 4'd3;

    // Microprogram addresses.
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UPC_IDLE    = 3'd0;
    localparam logic [UPC_W-1:0] UPC_INIT    = 3'd1;
    localparam logic [UPC_W-1:0] UPC_COUNT   = 3'd2;
    localparam logic [UPC_W-1:0] UPC_ADVANCE = 3'd3;
    localparam logic [UPC_W-1:0] UPC_EMIT    = 3'd4;
    localparam logic [UPC_W-1:0] UPC_TICK    = 3'd5;
    localparam logic [UPC_W-1:0] UPC_EXC     = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_COUNT,
        OP_ADVANCE,
        OP_EMIT,
        OP_TICK,
        OP_EXC
    } t_op;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_IDX_MORE,
        COND_WALK
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_ctrl;

    typedef struct packed {
        logic idx_more;
        logic walk_again;
        logic out_busy;
    } t_status;

    // Control store. A count or walk word jumps to its target while the
    // condition holds and falls through to the next address otherwise.
    function automatic t_uword micro_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        begin
            unique case (addr)
                UPC_IDLE:    w = '{op: OP_NOP,     cond: COND_DISPATCH, target: UPC_IDLE};
                UPC_INIT:    w = '{op: OP_INIT,    cond: COND_ALWAYS,   target: UPC_COUNT};
                UPC_COUNT:   w = '{op: OP_COUNT,   cond: COND_IDX_MORE, target: UPC_COUNT};
                UPC_ADVANCE: w = '{op: OP_ADVANCE, cond: COND_WALK,     target: UPC_ADVANCE};
                UPC_EMIT:    w = '{op: OP_EMIT,    cond: COND_ALWAYS,   target: UPC_IDLE};
                UPC_TICK:    w = '{op: OP_TICK,    cond: COND_ALWAYS,   target: UPC_EMIT};
                UPC_EXC:     w = '{op: OP_EXC,     cond: COND_ALWAYS,   target: UPC_EMIT};
                default:     w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: UPC_IDLE};
            endcase
            return w;
        end
    endfunction

    // A dead clock restarts at zero; a live one wraps at four.
    function automatic logic [CLK_W-1:0] clock_advance(input logic [CLK_W-1:0] c);
        logic [1:0] low;
        begin
            low = c[1:0] + 2'd1;
            return (c == CLK_DEAD) ? '0 : {1'b0, low};
        end
    endfunction

endpackage

// ===== src/tsrr_seq.sv =====
module tsrr_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [tsrr_pkg::CMD_W-1:0]   i_cmd,
    input  tsrr_pkg::t_status            i_status,
    output logic                         o_s_tready,
    output tsrr_pkg::t_ctrl              o_ctrl
);

    logic [tsrr_pkg::UPC_W-1:0] r_upc;
    logic [tsrr_pkg::UPC_W-1:0] n_upc;
    logic [tsrr_pkg::UPC_W-1:0] upc_inc;
    logic [tsrr_pkg::UPC_W-1:0] entry;
    tsrr_pkg::t_uword           word;
    logic                       accept;

    assign word       = tsrr_pkg::micro_rom(r_upc);
    assign o_s_tready = (r_upc == tsrr_pkg::UPC_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign upc_inc    = r_upc + 1'b1;
    assign o_ctrl     = '{op: word.op, load: accept};

    always_comb begin
        unique case (i_cmd)
            tsrr_pkg::CMD_SCHED: entry = tsrr_pkg::UPC_INIT;
            tsrr_pkg::CMD_TICK:  entry = tsrr_pkg::UPC_TICK;
            tsrr_pkg::CMD_EXC:   entry = tsrr_pkg::UPC_EXC;
            default:             entry = tsrr_pkg::UPC_EMIT;
        endcase
    end

    always_comb begin
        priority if (word.op == tsrr_pkg::OP_EMIT && i_status.out_busy) begin
            n_upc = r_upc;
        end else begin
            unique case (word.cond)
                tsrr_pkg::COND_ALWAYS:   n_upc = word.target;
                tsrr_pkg::COND_DISPATCH: n_upc = accept ? entry : r_upc;
                tsrr_pkg::COND_IDX_MORE: n_upc = i_status.idx_more ? word.target : upc_inc;
                tsrr_pkg::COND_WALK:     n_upc = i_status.walk_again ? word.target : upc_inc;
                default:                 n_upc = tsrr_pkg::UPC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= tsrr_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_upc != tsrr_pkg::UPC_IDLE))
        else $error("sequencer stayed idle after taking a transaction");

    a_init_then_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == tsrr_pkg::UPC_INIT) |=> (r_upc == tsrr_pkg::UPC_COUNT))
        else $error("live count pass did not follow its setup step");

    a_walk_ends_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == tsrr_pkg::UPC_ADVANCE && !i_status.walk_again)
            |=> (r_upc == tsrr_pkg::UPC_EMIT))
        else $error("slot walk did not end in the emit step");
`endif

endmodule

// ===== src/tsrr_dpath.sv =====
module tsrr_dpath #(
    parameter int NUM_SLOTS = tsrr_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tsrr_pkg::t_ctrl                 i_ctrl,
    input  logic [tsrr_pkg::CMD_W-1:0]      i_cmd,
    input  logic [tsrr_pkg::ID_W-1:0]       i_task_id,
    input  logic                            i_cfg_we,
    input  logic [tsrr_pkg::TURNS_W-1:0]    i_cfg_wdata,
    input  logic                            i_m_tready,
    output tsrr_pkg::t_status               o_status,
    output logic                            o_m_tvalid,
    output logic [tsrr_pkg::M_DATA_W-1:0]   o_m_tdata
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CLK_W  = tsrr_pkg::CLK_W;
    localparam int TRN_W  = tsrr_pkg::TURNS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    logic [tsrr_pkg::CMD_W-1:0]   r_cmd;
    logic [SLOT_W-1:0]            r_id;
    logic                         r_id_ok;
    logic                         r_dead [NUM_SLOTS];
    logic [CLK_W-1:0]             r_tclk [NUM_SLOTS];
    logic [CLK_W-1:0]             r_fclk [NUM_SLOTS];
    logic [SLOT_W-1:0]            r_cur;
    logic [SLOT_W-1:0]            r_idx;
    logic [CNT_W-1:0]             r_laps;
    logic [CNT_W-1:0]             r_live;
    logic [TRN_W-1:0]             r_ttc;
    logic [TRN_W-1:0]             r_frc;
    logic                         r_mode;
    logic [CLK_W-1:0]             r_gen;
    logic [TRN_W-1:0]             r_turns;
    logic                         r_out_valid;
    logic [tsrr_pkg::M_DATA_W-1:0] r_out_data;

    logic [SLOT_W+tsrr_pkg::ID_W-1:0] id_ext;
    logic [SLOT_W+2:0]            slot_ext;
    logic [SLOT_W-1:0]            cur_next;
    logic [CNT_W-1:0]             laps_next;
    logic [TRN_W-1:0]             ttc_inc;
    logic [TRN_W-1:0]             frc_inc;
    logic                         frc_done;
    logic                         is_sched;
    logic                         out_free;
    logic [tsrr_pkg::M_DATA_W-1:0] n_out_data;

    assign id_ext    = {{SLOT_W{1'b0}}, i_task_id};
    assign slot_ext  = {3'b000, r_cur};
    assign cur_next  = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
    assign laps_next = r_laps + 1'b1;
    assign ttc_inc   = r_ttc + 1'b1;
    assign frc_inc   = (r_frc == '1) ? r_frc : r_frc + 1'b1;
    assign frc_done  = (32'(frc_inc) >= 32'(r_live));
    assign is_sched  = (r_cmd == tsrr_pkg::CMD_SCHED);
    assign out_free  = !r_out_valid || i_m_tready;

    assign o_status.idx_more   = (r_idx != LAST_SLOT);
    assign o_status.walk_again = r_dead[cur_next] && (r_live != '0)
                                 && (32'(laps_next) < NUM_SLOTS);
    assign o_status.out_busy   = !out_free;

    // Result fields from the highest bit down.
    assign n_out_data = {1'b0, r_gen, r_fclk[r_cur], r_tclk[r_cur], r_mode,
                         is_sched && (r_live == '0), is_sched && !r_mode,
                         slot_ext[2:0]};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_idx       <= '0;
            r_laps      <= '0;
            r_live      <= '0;
            r_ttc       <= '0;
            r_frc       <= '0;
            r_mode      <= 1'b1;
            r_gen       <= tsrr_pkg::CLK_DEAD;
            r_turns     <= tsrr_pkg::TURNS_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_dead[i] <= 1'b0;
                r_tclk[i] <= '0;
                r_fclk[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_turns <= i_cfg_wdata;
            end
            // The emit step fills the output register whenever it is free;
            // otherwise a held result stays until it is taken.
            r_out_valid <= (i_ctrl.op == tsrr_pkg::OP_EMIT && out_free)
                           || (r_out_valid && !i_m_tready);
            unique case (i_ctrl.op)
                tsrr_pkg::OP_INIT: begin
                    r_idx  <= '0;
                    r_laps <= '0;
                    r_live <= '0;
                end
                tsrr_pkg::OP_COUNT: begin
                    r_live <= r_live + CNT_W'(!r_dead[r_idx]);
                    r_idx  <= r_idx + 1'b1;
                end
                tsrr_pkg::OP_ADVANCE: begin
                    r_cur  <= cur_next;
                    r_laps <= laps_next;
                end
                tsrr_pkg::OP_TICK: begin
                    r_gen <= tsrr_pkg::clock_advance(r_gen);
                    if (r_mode) begin
                        r_tclk[r_cur] <= tsrr_pkg::clock_advance(r_tclk[r_cur]);
                        if (ttc_inc == r_turns) begin
                            r_ttc  <= '0;
                            r_mode <= 1'b0;
                        end else begin
                            r_ttc <= ttc_inc;
                        end
                    end else begin
                        r_fclk[r_cur] <= tsrr_pkg::clock_advance(r_fclk[r_cur]);
                        if (frc_done) begin
                            r_frc  <= '0;
                            r_mode <= 1'b1;
                        end else begin
                            r_frc <= frc_inc;
                        end
                    end
                end
                tsrr_pkg::OP_EXC: begin
                    if (r_id_ok) begin
                        r_dead[r_id] <= 1'b1;
                        r_tclk[r_id] <= tsrr_pkg::CLK_DEAD;
                        r_fclk[r_id] <= tsrr_pkg::CLK_DEAD;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_cmd;
            r_id    <= id_ext[SLOT_W-1:0];
            r_id_ok <= (32'(i_task_id) < NUM_SLOTS);
        end
        if (i_ctrl.op == tsrr_pkg::OP_EMIT && out_free) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_live_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= NUM_SLOTS)
        else $error("live count exceeds the number of slots");

    a_laps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_laps) <= NUM_SLOTS)
        else $error("slot walk ran past one full lap");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == tsrr_pkg::OP_EMIT && out_free) |=> r_out_valid)
        else $error("emit step did not present a result");
`endif

endmodule

// ===== src/task_flag_round_robin_scheduler.sv =====
// Round-robin task scheduler over NUM_SLOTS slots. Each input transaction
// carries a command in s_tuser: schedule (0) recounts the live tasks and
// steps the current slot forward past dead ones for at most one lap,
// reporting whether the task body or its flag handler runs; tick (1)
// advances the general clock and the current slot's task or flag clock and
// moves between task mode and flag mode; exception (2) kills the slot given
// by task_id; command 3 only reports. Every transaction yields exactly one
// result transaction on the master side. Items are handled one at a time
// by a small microprogram: a schedule runs a setup step, the live count and
// the slot walk, which each visit one slot per cycle, before the emit step;
// tick and exception each run their own step before it, and the unused
// command goes straight to the emit step. A new transaction is taken as soon
// as the previous result sits in the output register, even if it has not
// been taken yet; a result still held there stalls the next emit step. The
// configuration write sets how many task ticks pass before flag mode, and
// takes effect at once.
module task_flag_round_robin_scheduler #(
    parameter int NUM_SLOTS = tsrr_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input transactions.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [2:0] task_id, [7:3] error_code
    input  logic [tsrr_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [1:0] command
    input  logic [tsrr_pkg::CMD_W-1:0]      i_s_tuser,
    // Result transactions.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] chosen_slot, [3] run_flag_handler, [4] all_dead, [5] task_mode,
    // [8:6] task_clock_out, [11:9] flag_clock_out, [14:12] general_clock,
    // [15] zero
    output logic [tsrr_pkg::M_DATA_W-1:0]   o_m_tdata,
    // Task turns before flag mode.
    input  logic                            i_cfg_we,
    input  logic [tsrr_pkg::TURNS_W-1:0]    i_cfg_wdata
);

    tsrr_pkg::t_ctrl   ctrl;
    tsrr_pkg::t_status status;

    // The sequencer owns the microprogram counter and the input handshake.
    tsrr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_ctrl     (ctrl)
    );

    // The datapath holds the slot records, counters and output register.
    // The error code is not kept, since no result ever reports it.
    tsrr_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cmd       (i_s_tuser),
        .i_task_id   (i_s_tdata[2:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ===== bench/tb_task_flag_round_robin_scheduler.sv =====
module tb_task_flag_round_robin_scheduler;

    // The block runs with its default slot count, so the scheduler model in
    // this bench uses the same number.
    localparam int NUM_SLOTS = tsrr_pkg::DEFAULT_NUM_SLOTS;

    // The command field has a fourth code that the block must only report on.
    localparam logic [tsrr_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    // The slowest correct transaction is a schedule walking every slot twice,
    // plus a sender gap and a receiver stall. The limit below leaves a wide
    // margin over that for the whole run.
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 3 + 10;
    localparam int LONG_HOLD_CYCLES = 300;

    // One result transaction, laid out exactly as the master tdata bits 14:0.
    typedef struct packed {
        logic [tsrr_pkg::CLK_W-1:0] general_clock;
        logic [tsrr_pkg::CLK_W-1:0] flag_clock;
        logic [tsrr_pkg::CLK_W-1:0] task_clock;
        logic                       task_mode;
        logic                       all_dead;
        logic                       run_flag_handler;
        logic [2:0]                 chosen_slot;
    } t_sched_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [tsrr_pkg::S_DATA_W-1:0]    i_s_tdata = '0;
    logic [tsrr_pkg::CMD_W-1:0]       i_s_tuser = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [tsrr_pkg::M_DATA_W-1:0]    o_m_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [tsrr_pkg::TURNS_W-1:0]     i_cfg_wdata = '0;

    // Scheduler state as the bench believes it to be after every accepted
    // input transaction.
    bit                               slot_dead [NUM_SLOTS];
    logic [tsrr_pkg::CLK_W-1:0]       task_clk [NUM_SLOTS];
    logic [tsrr_pkg::CLK_W-1:0]       flag_clk [NUM_SLOTS];
    int                               cur_slot;
    logic [3:0]                       live_cnt;
    logic [tsrr_pkg::TURNS_W-1:0]     turn_cnt;
    logic [tsrr_pkg::TURNS_W-1:0]     flags_run;
    logic [tsrr_pkg::TURNS_W-1:0]     turns_setting;
    bit                               in_task_mode;
    logic [tsrr_pkg::CLK_W-1:0]       gen_clk;

    // Results that the block still owes, oldest first.
    t_sched_result                    pending_results [$];
    t_sched_result                    seen_result;
    t_sched_result                    due_result;

    int                               fail_count = 0;
    int                               cycle_count = 0;
    bit                               tx_idle_en = 1'b1;
    bit                               rx_idle_en = 1'b1;
    int                               hold_off_request = 0;

    task_flag_round_robin_scheduler #(
        .NUM_SLOTS (NUM_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The run is cut off here if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // A slot clock that was killed restarts at zero on its next tick, while
    // a live clock simply counts modulo four.
    function automatic logic [tsrr_pkg::CLK_W-1:0] next_slot_clock(
        input logic [tsrr_pkg::CLK_W-1:0] c);
        logic [1:0] wrapped;
        wrapped = c[1:0] + 2'd1;
        if (c == tsrr_pkg::CLK_DEAD) begin
            return '0;
        end
        return {1'b0, wrapped};
    endfunction

    function automatic void clear_scheduler_state();
        int i;
        for (i = 0; i < NUM_SLOTS; i++) begin
            slot_dead[i] = 1'b0;
            task_clk[i] = '0;
            flag_clk[i] = '0;
        end
        cur_slot = 0;
        live_cnt = '0;
        turn_cnt = '0;
        flags_run = '0;
        turns_setting = tsrr_pkg::TURNS_RESET;
        in_task_mode = 1'b1;
        gen_clk = tsrr_pkg::CLK_DEAD;
    endfunction

    // Apply one command to the scheduler state and return the result that
    // the block must produce for it.
    function automatic t_sched_result schedule_step(
        input logic [tsrr_pkg::CMD_W-1:0] cmd,
        input logic [tsrr_pkg::ID_W-1:0] id);
        t_sched_result r;
        int live;
        int steps;
        int i;
        r = '0;
        if (cmd == tsrr_pkg::CMD_SCHED) begin
            // Recount the live tasks, then walk forward past dead slots but
            // never more than one full lap.
            live = 0;
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (!slot_dead[i]) begin
                    live++;
                end
            end
            live_cnt = live[3:0];
            r.all_dead = (live == 0);
            cur_slot = (cur_slot + 1) % NUM_SLOTS;
            steps = 1;
            while (slot_dead[cur_slot] && live > 0 && steps < NUM_SLOTS) begin
                cur_slot = (cur_slot + 1) % NUM_SLOTS;
                steps++;
            end
            r.run_flag_handler = !in_task_mode;
        end else if (cmd == tsrr_pkg::CMD_TICK) begin
            gen_clk = next_slot_clock(gen_clk);
            if (in_task_mode) begin
                task_clk[cur_slot] = next_slot_clock(task_clk[cur_slot]);
                // The turn counter is four bits wide, so a setting of zero
                // is only met again after sixteen ticks.
                turn_cnt = turn_cnt + 1'b1;
                if (turn_cnt == turns_setting) begin
                    turn_cnt = '0;
                    in_task_mode = 1'b0;
                end
            end else begin
                flag_clk[cur_slot] = next_slot_clock(flag_clk[cur_slot]);
                if (flags_run < 4'd15) begin
                    flags_run = flags_run + 1'b1;
                end
                if (flags_run >= live_cnt) begin
                    flags_run = '0;
                    in_task_mode = 1'b1;
                end
            end
        end else if (cmd == tsrr_pkg::CMD_EXC) begin
            // The code itself never shows on the outputs; only the death of
            // the slot does.
            if (id < NUM_SLOTS) begin
                slot_dead[id] = 1'b1;
                task_clk[id] = tsrr_pkg::CLK_DEAD;
                flag_clk[id] = tsrr_pkg::CLK_DEAD;
            end
        end
        r.chosen_slot = cur_slot[2:0];
        r.task_mode = in_task_mode;
        r.task_clock = task_clk[cur_slot];
        r.flag_clock = flag_clk[cur_slot];
        r.general_clock = gen_clk;
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Every result transaction is matched against the oldest prediction.
    // Inputs and outputs are both sampled here just before the edge applies.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with nothing expected: %h",
                       o_m_tdata);
                fail_count++;
            end else begin
                due_result = pending_results.pop_front();
                seen_result = t_sched_result'(o_m_tdata[14:0]);
                check_field("chosen_slot", int'(due_result.chosen_slot),
                            int'(seen_result.chosen_slot));
                check_field("run_flag_handler", int'(due_result.run_flag_handler),
                            int'(seen_result.run_flag_handler));
                check_field("all_dead", int'(due_result.all_dead),
                            int'(seen_result.all_dead));
                check_field("task_mode", int'(due_result.task_mode),
                            int'(seen_result.task_mode));
                check_field("task_clock_out", int'($signed(due_result.task_clock)),
                            int'($signed(seen_result.task_clock)));
                check_field("flag_clock_out", int'($signed(due_result.flag_clock)),
                            int'($signed(seen_result.flag_clock)));
                check_field("general_clock", int'($signed(due_result.general_clock)),
                            int'($signed(seen_result.general_clock)));
            end
        end
    end

    // Result side ready control. A long hold-off asked for by a test is
    // counted down here, independent of the sender, so the block backs up.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request > 0) begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Offer one input transaction, possibly after a random gap, and record
    // the expected result at the edge where it is taken. Valid stays high on
    // return so back-to-back transactions follow without a gap.
    task automatic send_command(input logic [tsrr_pkg::CMD_W-1:0] cmd,
                                input logic [tsrr_pkg::ID_W-1:0] id,
                                input logic [tsrr_pkg::CODE_W-1:0] code);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {code, id};
        i_s_tuser <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(schedule_step(cmd, id));
    endtask

    // Stop offering and wait until the block has returned every result.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The register is only written once the block has nothing in flight.
    task automatic set_turns(input logic [tsrr_pkg::TURNS_W-1:0] turns);
        wait_for_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= turns;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        turns_setting = turns;
    endtask

    // Random traffic: mostly schedules and ticks so the mode machine keeps
    // cycling, a few unused commands, and rare exceptions so that slots die
    // slowly over the run instead of all at once.
    task automatic send_random_items(input int count, input int kill_odds);
        int k;
        int pick;
        logic [tsrr_pkg::CMD_W-1:0] cmd;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (kill_odds > 0 && $urandom_range(1, kill_odds) == 1) begin
                cmd = tsrr_pkg::CMD_EXC;
            end else if (pick < 45) begin
                cmd = tsrr_pkg::CMD_SCHED;
            end else if (pick < 94) begin
                cmd = tsrr_pkg::CMD_TICK;
            end else begin
                cmd = CMD_NONE;
            end
            send_command(cmd, tsrr_pkg::ID_W'($urandom_range(0, 7)),
                         tsrr_pkg::CODE_W'($urandom_range(0, 31)));
        end
    endtask

    // Right after reset an unused command must report the reset state, with
    // the general clock still at minus one. Its fields are at their maximum.
    task automatic test_reset_report();
        send_command(CMD_NONE, 3'd7, 5'd31);
    endtask

    // Before any schedule the live count is zero, so with one task turn the
    // very first flag tick already returns to task mode.
    task automatic test_flag_exit_without_live();
        set_turns(4'd1);
        repeat (3) send_command(tsrr_pkg::CMD_TICK, 3'd0, 5'd0);
    endtask

    // Schedules in flag mode pick the flag handler; flag mode stays on until
    // the flag ticks reach the live count.
    task automatic test_schedule_modes();
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_TICK, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_TICK, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block must stall its input. Afterwards the sender
    // pauses until every result is back.
    task automatic test_output_backpressure();
        wait_for_results();
        hold_off_request = LONG_HOLD_CYCLES;
        send_random_items(40, 0);
        wait_for_results();
    endtask

    // Killing the current slot makes its clocks read minus one, and a tick
    // on that dead clock restarts it at zero. A schedule must then skip the
    // next slot once it is dead as well.
    task automatic test_exception_paths();
        logic [2:0] victim;
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
        wait_for_results();
        victim = cur_slot[2:0];
        send_command(tsrr_pkg::CMD_EXC, victim, 5'd31);
        send_command(tsrr_pkg::CMD_TICK, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_EXC, victim + 3'd1, 5'd0);
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
    endtask

    // With every slot dead a schedule raises all_dead and still moves the
    // current slot by exactly one.
    task automatic test_all_dead();
        int id;
        for (id = 0; id < NUM_SLOTS; id++) begin
            send_command(tsrr_pkg::CMD_EXC, id[2:0],
                         tsrr_pkg::CODE_W'($urandom_range(0, 31)));
        end
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_TICK, 3'd0, 5'd0);
        send_command(tsrr_pkg::CMD_SCHED, 3'd0, 5'd0);
    endtask

    initial begin
        int chunk;
        clear_scheduler_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_report();
        test_flag_exit_without_live();
        test_schedule_modes();

        // All slots alive, default number of task turns.
        set_turns(tsrr_pkg::TURNS_RESET);
        send_random_items(280, 0);

        test_output_backpressure();
        test_exception_paths();

        // Fifteen task turns, slots start to die.
        set_turns(4'd15);
        send_random_items(280, 120);

        // A setting of zero means sixteen task ticks; the receiver never
        // stalls here.
        rx_idle_en = 1'b0;
        set_turns(4'd0);
        send_random_items(280, 120);
        rx_idle_en = 1'b1;

        for (chunk = 0; chunk < 4; chunk++) begin
            set_turns(tsrr_pkg::TURNS_W'($urandom_range(1, 15)));
            send_random_items(70, 120);
        end

        test_all_dead();

        // The last stretch runs at full rate on both sides.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_turns(4'd1);
        send_random_items(100, 0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
